### hdl/cda_pkg.sv
// Shared types, constants and a calendar function for the date adder.
package cda_pkg;

    // Width of the running increment; covers a full 16-bit amount plus month-length carries
    localparam int INC_W = 18;

    localparam logic [13:0] YEAR_MAX = 14'd16383;
    localparam logic [3:0]  MONTH_MAX = 4'd12;

    localparam logic signed [INC_W-1:0] ONE_S       = 18'sd1;
    localparam logic signed [INC_W-1:0] MONTHS_S    = 18'sd12;
    localparam logic signed [INC_W-1:0] YEAR_MAX_S  = 18'sd16383;

    // Command kinds carried in the input beat
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_YEARS  = 2'd1;
    localparam logic [1:0] KIND_MONTHS = 2'd2;
    localparam logic [1:0] KIND_DAYS   = 2'd3;

    // Multiplicative inverse of 25 modulo 2^14 and the largest image of a multiple of 25
    localparam logic [13:0] INV25      = 14'd7209;
    localparam logic [13:0] DIV25_LIMIT = 14'd655;

    typedef struct packed {
        logic [1:0]         kind;
        logic [13:0]        load_year;
        logic [3:0]         load_month;
        logic [4:0]         load_day;
        logic signed [15:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic        warning;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_YEARS,
        OP_MONTHS,
        OP_DAYS
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic step_done;
    } dp_status_t;

    // Number of days in month m of year y, with the 4/100/400 leap rule
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [13:0] y);
        logic [27:0] prod;
        logic        div25;
        logic        leap;
        logic [4:0]  len;
        prod  = 28'(y) * 28'(INV25);
        div25 = (prod[13:0] <= DIV25_LIMIT);
        leap  = (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### hdl/cda_datapath.sv
// Date registers and the single-step year, month and day arithmetic.
module cda_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cda_pkg::in_item_t     item,
    input  cda_pkg::dp_cmd_t      cmd,
    output cda_pkg::dp_status_t   status,
    output cda_pkg::out_item_t    result
);

    logic [13:0]                       year_reg,  year_next;
    logic [3:0]                        month_reg, month_next;
    logic [4:0]                        day_reg,   day_next;
    logic                              warn_reg,  warn_next;
    logic                              back_reg,  back_next;
    logic signed [cda_pkg::INC_W-1:0]  inc_reg,   inc_next;

    logic signed [cda_pkg::INC_W-1:0]  year_s;
    logic signed [cda_pkg::INC_W-1:0]  month_s;
    logic signed [cda_pkg::INC_W-1:0]  day_s;
    logic signed [cda_pkg::INC_W-1:0]  len_s;
    logic signed [cda_pkg::INC_W-1:0]  year_sum;
    logic signed [cda_pkg::INC_W-1:0]  month_sum;
    logic signed [cda_pkg::INC_W-1:0]  day_sum;
    logic [4:0]                        len;
    logic                              inc_zero;

    // Widen the held date for signed arithmetic
    assign year_s   = $signed({{(cda_pkg::INC_W-14){1'b0}}, year_reg});
    assign month_s  = $signed({{(cda_pkg::INC_W-4){1'b0}}, month_reg});
    assign day_s    = $signed({{(cda_pkg::INC_W-5){1'b0}}, day_reg});
    assign len      = cda_pkg::days_in_month(month_reg, year_reg);
    assign len_s    = $signed({{(cda_pkg::INC_W-5){1'b0}}, len});
    assign year_sum  = year_s + inc_reg;
    assign month_sum = month_s + inc_reg;
    assign day_sum   = day_s + inc_reg;
    assign inc_zero  = (inc_reg == '0);

    // Work out one step of the current command
    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        warn_next  = warn_reg;
        back_next  = back_reg;
        inc_next   = inc_reg;

        if (cmd.capture)
        begin
            warn_next = 1'b0;
            back_next = 1'b0;
            if (item.kind == cda_pkg::KIND_LOAD)
            begin
                inc_next  = '0;
                year_next = item.load_year;
                if (item.load_month == 4'd0)
                    month_next = 4'd1;
                else if (item.load_month > cda_pkg::MONTH_MAX)
                    month_next = cda_pkg::MONTH_MAX;
                else
                    month_next = item.load_month;
                day_next = (item.load_day == 5'd0) ? 5'd1 : item.load_day;
            end
            else
            begin
                inc_next = $signed({{(cda_pkg::INC_W-16){item.amount[15]}}, item.amount});
            end
        end
        else
        begin
            case (cmd.op)
                cda_pkg::OP_YEARS:
                begin
                    if (!inc_zero)
                    begin
                        if (year_sum[cda_pkg::INC_W-1] || (year_sum > cda_pkg::YEAR_MAX_S))
                            warn_next = 1'b1;
                        else
                            year_next = year_sum[13:0];
                        inc_next = '0;
                    end
                end
                cda_pkg::OP_MONTHS:
                begin
                    if (!inc_zero)
                    begin
                        if (month_sum > cda_pkg::MONTHS_S)
                        begin
                            // Carry into the next year
                            if (year_reg == cda_pkg::YEAR_MAX)
                                warn_next = 1'b1;
                            else
                                year_next = year_reg + 14'd1;
                            inc_next = inc_reg - cda_pkg::MONTHS_S;
                        end
                        else if (month_sum < cda_pkg::ONE_S)
                        begin
                            // Borrow from the previous year
                            if (year_reg == 14'd0)
                                warn_next = 1'b1;
                            else
                                year_next = year_reg - 14'd1;
                            inc_next = inc_reg + cda_pkg::MONTHS_S;
                        end
                        else
                        begin
                            month_next = month_sum[3:0];
                            inc_next   = '0;
                        end
                    end
                end
                cda_pkg::OP_DAYS:
                begin
                    if (back_reg)
                    begin
                        // Add back the length of the month just stepped into
                        inc_next  = inc_reg + len_s;
                        back_next = 1'b0;
                    end
                    else if (!inc_zero)
                    begin
                        if (day_sum > len_s)
                        begin
                            // Advance one month
                            inc_next = inc_reg - len_s;
                            if (month_reg == cda_pkg::MONTH_MAX)
                            begin
                                month_next = 4'd1;
                                if (year_reg == cda_pkg::YEAR_MAX)
                                    warn_next = 1'b1;
                                else
                                    year_next = year_reg + 14'd1;
                            end
                            else
                            begin
                                month_next = month_reg + 4'd1;
                            end
                        end
                        else if (day_sum < cda_pkg::ONE_S)
                        begin
                            // Step back one month; its length is added next cycle
                            back_next = 1'b1;
                            if (month_reg == 4'd1)
                            begin
                                month_next = cda_pkg::MONTH_MAX;
                                if (year_reg == 14'd0)
                                    warn_next = 1'b1;
                                else
                                    year_next = year_reg - 14'd1;
                            end
                            else
                            begin
                                month_next = month_reg - 4'd1;
                            end
                        end
                        else
                        begin
                            day_next = day_sum[4:0];
                            inc_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold the date and the running increment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= 14'd1900;
            month_reg <= 4'd1;
            day_reg   <= 5'd1;
            warn_reg  <= 1'b0;
            back_reg  <= 1'b0;
            inc_reg   <= '0;
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            warn_reg  <= warn_next;
            back_reg  <= back_next;
            inc_reg   <= inc_next;
        end
    end

    assign status.step_done = inc_zero && !back_reg;

    assign result.cur_year  = year_reg;
    assign result.cur_month = month_reg;
    assign result.cur_day   = day_reg;
    assign result.warning   = warn_reg;

endmodule

### hdl/cda_ctrl.sv
// Command sequencer: accepts a beat, steps the datapath until it settles, strobes the result.
module cda_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            kind,
    input  cda_pkg::dp_status_t   status,
    output cda_pkg::dp_cmd_t      cmd,
    output logic                  busy,
    output logic                  done
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t          state_reg;
    cda_pkg::dp_op_t op_reg;
    logic            busy_reg;
    logic            done_reg;
    logic            accept;
    cda_pkg::dp_op_t kind_op;

    assign accept = start && !busy_reg;

    // Map the command kind onto a datapath step
    always_comb
    begin
        case (kind)
            cda_pkg::KIND_YEARS:  kind_op = cda_pkg::OP_YEARS;
            cda_pkg::KIND_MONTHS: kind_op = cda_pkg::OP_MONTHS;
            cda_pkg::KIND_DAYS:   kind_op = cda_pkg::OP_DAYS;
            default:              kind_op = cda_pkg::OP_NONE;
        endcase
    end

    // Hold state, the current step and the handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= cda_pkg::OP_NONE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        op_reg    <= kind_op;
                        busy_reg  <= 1'b1;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (status.step_done)
                    begin
                        op_reg    <= cda_pkg::OP_NONE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.capture = accept;
    assign cmd.op      = op_reg;
    assign busy        = busy_reg;
    assign done        = done_reg;

endmodule

### hdl/calendar_date_adder_core.sv
// Top level of the Gregorian date adder: sequencer plus date datapath.
//
// Usage: drive a command beat on item and raise start; the beat is taken at
// the rising edge where start is high and busy is low. busy then stays high
// while the command runs. The resulting date and the warning flag appear on
// result, marked by done, which is high for a single cycle; the receiver has no way to
// hold them off, so it must take them in that cycle.
//
// Steps after the accepting edge: a load or a zero amount needs none; a
// non-zero year add sets the year, or raises the warning, in a single step.
// A month add moves the year by one per step until the month falls in
// range, then sets the month. A day add moves the month forward per step
// while the day overflows, and back while it underflows, each backward
// move followed by a step that adds that month's length; then it sets the
// day. A new beat is taken in the same cycle as done at the earliest.
//
// Reset (rst_n low, asynchronous) sets the date to 1 January 1900, clears
// the warning flag and leaves the block idle.
module calendar_date_adder_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  cda_pkg::in_item_t    item,
    output logic                 busy,
    output logic                 done,
    output cda_pkg::out_item_t   result
);

    cda_pkg::dp_cmd_t    cmd;
    cda_pkg::dp_status_t status;

    cda_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    cda_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule
